// ----- hw/rtl/rths_pkg.sv -----
`default_nettype none

package rths_pkg;

    // Field widths of the pixel channels and of the divider lanes.
    localparam int ChanW  = 8;
    localparam int RemW   = 18;
    localparam int QuoW   = 8;
    localparam int NCells = QuoW;

    // One input pixel.
    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } t_rgb;

    // One converted result.
    typedef struct packed {
        logic [ChanW-1:0] hue;
        logic [ChanW-1:0] saturation;
        logic [ChanW-1:0] brightness;
    } t_hsv;

    // One restoring-division lane: partial remainder, divisor aligned to the
    // quotient bit under work, and the quotient bits found so far.
    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [RemW-1:0] dsh;
        logic [QuoW-1:0] quo;
    } t_lane;

    // What moves from cell to cell: both division lanes and the value.
    typedef struct packed {
        t_lane            hue;
        t_lane            sat;
        logic [ChanW-1:0] bright;
    } t_cell_data;

    // One quotient bit: subtract the aligned divisor where it fits, then
    // align the divisor to the next lower bit.
    function automatic t_lane lane_step(input t_lane l);
        t_lane r;
        r = l;
        if (l.rem >= l.dsh) begin
            r.rem = l.rem - l.dsh;
            r.quo = {l.quo[QuoW-2:0], 1'b1};
        end else begin
            r.quo = {l.quo[QuoW-2:0], 1'b0};
        end
        r.dsh = l.dsh >> 1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rths_front.sv -----
`default_nettype none

module rths_front
    import rths_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_rgb       i_pixel,
    output logic            o_ready,
    output logic            o_valid,
    output t_cell_data      o_data,
    input  wire logic       i_ready
);

    logic             r_valid;
    t_cell_data       r_data;
    t_cell_data       n_data;

    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] delta;
    logic [11:0]      d12;
    logic signed [11:0] r_s;
    logic signed [11:0] g_s;
    logic signed [11:0] b_s;
    logic signed [11:0] m_s;
    logic [10:0]      m;
    logic [RemW-1:0]  num_hue;
    logic [9:0]       den_hue;
    logic [15:0]      num_sat;
    logic [ChanW-1:0] den_sat;

    // Largest and smallest channel.
    always_comb begin
        hi = (i_pixel.red > i_pixel.green) ? i_pixel.red : i_pixel.green;
        if (i_pixel.blue > hi) begin
            hi = i_pixel.blue;
        end
        lo = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        if (i_pixel.blue < lo) begin
            lo = i_pixel.blue;
        end
        delta = hi - lo;
    end

    // Hue in sixths of a turn, times delta: the sector offset plus the
    // channel difference, wrapped into one turn when it falls below zero.
    // Ties go to red first and then to green.
    always_comb begin
        d12 = {4'b0, delta};
        r_s = $signed({4'b0, i_pixel.red});
        g_s = $signed({4'b0, i_pixel.green});
        b_s = $signed({4'b0, i_pixel.blue});
        if (hi == i_pixel.red) begin
            m_s = g_s - b_s;
            if (m_s < 0) begin
                m_s = m_s + $signed((d12 << 2) + (d12 << 1));
            end
        end else if (hi == i_pixel.green) begin
            m_s = $signed(d12 << 1) + b_s - r_s;
        end else begin
            m_s = $signed(d12 << 2) + r_s - g_s;
        end
        m = m_s[10:0];
    end

    // hue = floor(127*m / (3*delta)), saturation = floor(254*delta / max).
    // A zero divisor only comes with a zero numerator, so it is set to one
    // and the quotient comes out zero.
    always_comb begin
        num_hue = ({7'b0, m} << 7) - {7'b0, m};
        den_hue = ({2'b0, delta} << 1) + {2'b0, delta};
        if (delta == '0) begin
            den_hue = 10'd1;
        end
        num_sat = ({8'b0, delta} << 8) - ({8'b0, delta} << 1);
        den_sat = (hi == '0) ? ChanW'(1) : hi;

        n_data.hue.rem = num_hue;
        n_data.hue.dsh = {1'b0, den_hue, 7'b0};
        n_data.hue.quo = '0;
        n_data.sat.rem = {2'b0, num_sat};
        n_data.sat.dsh = {3'b0, den_sat, 7'b0};
        n_data.sat.quo = '0;
        n_data.bright  = hi;
    end

    // Stage register; it takes a transfer when empty or when it drains.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hw/rtl/rths_cell.sv -----
`default_nettype none

module rths_cell
    import rths_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_cell_data i_data,
    output logic            o_ready,
    output logic            o_valid,
    output t_cell_data      o_data,
    input  wire logic       i_ready
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    // One quotient bit of each lane; the value rides along.
    always_comb begin
        n_data.hue    = lane_step(i_data.hue);
        n_data.sat    = lane_step(i_data.sat);
        n_data.bright = i_data.bright;
    end

    // The cell takes a transfer when empty or when its neighbor takes its own.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hue_saturation.sv -----
// Channel   Direction  Handshake            Payload
// pixel     in         i_valid / o_stall    i_pixel : red, green, blue
// result    out        o_valid / i_stall    o_hsv   : hue, saturation, brightness
//
// One pixel enters per cycle while no stall holds the row; each result passes
// one front stage and then a row of 8 divider cells, one quotient bit each.
// Reset empties every stage; no store needs clearing.
// A stall holds the last cell and reaches back in the same cycle through
// every full stage, so empty stages keep filling while a result waits.
`default_nettype none

module rgb_to_hue_saturation
    import rths_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_rgb i_pixel,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_hsv      o_hsv
);

    logic       front_ready;
    logic       front_valid;
    t_cell_data front_data;

    logic       cell_valid [NCells+1];
    t_cell_data cell_data  [NCells+1];
    logic       cell_ready [NCells+1];

    // Channel extremes, sector and divider operands.
    rths_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_ready (front_ready),
        .o_valid (front_valid),
        .o_data  (front_data),
        .i_ready (cell_ready[0])
    );

    assign o_stall       = !front_ready;
    assign cell_valid[0] = front_valid;
    assign cell_data[0]  = front_data;

    // Row of divider cells, most significant quotient bit first.
    for (genvar k = 0; k < NCells; k++) begin : g_cell
        rths_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .i_data  (cell_data[k]),
            .o_ready (cell_ready[k]),
            .o_valid (cell_valid[k+1]),
            .o_data  (cell_data[k+1]),
            .i_ready (cell_ready[k+1])
        );
    end

    // The last cell is the output register.
    assign cell_ready[NCells] = !i_stall;
    assign o_valid            = cell_valid[NCells];
    assign o_hsv.hue          = cell_data[NCells].hue.quo;
    assign o_hsv.saturation   = cell_data[NCells].sat.quo;
    assign o_hsv.brightness   = cell_data[NCells].bright;

endmodule

`default_nettype wire
